// ===== rtl/range_mul_add_point_query_mod_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for range_mul_add_point_query_mod
// Checks compile in when SYNTH is not defined, and vanish otherwise.
// ----------------------------------------------------------------------------
`ifndef RANGE_MUL_ADD_POINT_QUERY_MOD_DEFINES_SVH
`define RANGE_MUL_ADD_POINT_QUERY_MOD_DEFINES_SVH

`ifndef SYNTH
// Check that is switched off while reset is asserted.
`define RMAPQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("range_mul_add_point_query_mod: check failed");
// Check that also holds during reset.
`define RMAPQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("range_mul_add_point_query_mod: check failed");
`else
`define RMAPQ_ASSERT(lbl, clk, rstn, prop)
`define RMAPQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/rmapq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmapq_pkg
// Shared constants and types of the range multiply/add point query block.
// ----------------------------------------------------------------------------
package rmapq_pkg;

    localparam int unsigned MODULUS     = 10007;
    localparam int unsigned MAX_LEN     = 1024;
    localparam int unsigned BLOCK_SIZE  = 32;
    localparam int unsigned NUM_BLOCKS  = (MAX_LEN + BLOCK_SIZE - 1) / BLOCK_SIZE;

    localparam int unsigned VAL_W  = 14;
    localparam int unsigned POS_W  = 11;
    localparam int unsigned ADDR_W = $clog2(MAX_LEN);
    localparam int unsigned OFS_W  = $clog2(BLOCK_SIZE);
    localparam int unsigned BLK_W  = $clog2(NUM_BLOCKS);

    // Modular reduction by a scaled reciprocal.
    localparam int unsigned PROD_W      = 2 * VAL_W;
    localparam int unsigned RECIP_SHIFT = PROD_W;
    localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / MODULUS;
    localparam int unsigned QUO_W       = 15;
    localparam int unsigned REM_W       = 15;

    typedef enum logic [1:0] {
        OP_MUL   = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2,
        OP_LOAD  = 2'd3
    } t_op;

    typedef logic [VAL_W-1:0]  t_val;
    typedef logic [ADDR_W-1:0] t_addr;

endpackage

// ===== rtl/rmapq_in_if.sv =====
// ----------------------------------------------------------------------------
// rmapq_in_if
// Request channel: operation, range and operand with valid/ready.
// ----------------------------------------------------------------------------
interface rmapq_in_if;
    logic                                valid;
    logic                                ready;
    rmapq_pkg::t_op                      operation;
    logic [rmapq_pkg::POS_W-1:0]         left;
    logic [rmapq_pkg::POS_W-1:0]         right;
    logic [rmapq_pkg::VAL_W-1:0]         operand;

    modport source (output valid, operation, left, right, operand, input ready);
    modport sink   (input valid, operation, left, right, operand, output ready);
endinterface

// ===== rtl/rmapq_out_if.sv =====
// ----------------------------------------------------------------------------
// rmapq_out_if
// Result channel: element value and status with valid/ready.
// ----------------------------------------------------------------------------
interface rmapq_out_if;
    logic                        valid;
    logic                        ready;
    logic [rmapq_pkg::VAL_W-1:0] value;
    logic                        status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

// ===== rtl/rmapq_mulmod.sv =====
// ----------------------------------------------------------------------------
// rmapq_mulmod
// Four-stage pipelined (a * b + c) mod 10007 with a passed-through tag.
// ----------------------------------------------------------------------------
module rmapq_mulmod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  rmapq_pkg::t_val              i_a,
    input  rmapq_pkg::t_val              i_b,
    input  rmapq_pkg::t_val              i_c,
    input  rmapq_pkg::t_addr             i_tag,
    output logic                         o_done,
    output logic                         o_busy,
    output rmapq_pkg::t_val              o_res,
    output rmapq_pkg::t_addr             o_tag
);
    import rmapq_pkg::*;

    logic                     r_v1, r_v2, r_v3, r_v4;
    logic [PROD_W-1:0]        r_p1, r_p2;
    logic [QUO_W-1:0]         r_q2;
    logic [REM_W-1:0]         r_r3;
    t_val                     r_c1, r_c2, r_c3;
    t_addr                    r_t1, r_t2, r_t3, r_t4;
    t_val                     r_res;

    logic [PROD_W+QUO_W-1:0]  recip_prod;
    logic [PROD_W:0]          q_times_p;
    logic [PROD_W:0]          diff;
    logic [REM_W-1:0]         rem1;
    logic [REM_W-1:0]         sum;
    logic [REM_W-1:0]         sum_red;

    // The quotient estimate undershoots by at most two, so the remainder
    // stays below three times the modulus.
    assign recip_prod = (PROD_W+QUO_W)'(r_p1) * (PROD_W+QUO_W)'(RECIP);
    assign q_times_p  = (PROD_W+1)'(r_q2) * (PROD_W+1)'(MODULUS);
    assign diff       = (PROD_W+1)'(r_p2) - q_times_p;

    always_comb begin
        if (r_r3 >= REM_W'(2 * MODULUS)) begin
            rem1 = r_r3 - REM_W'(2 * MODULUS);
        end else if (r_r3 >= REM_W'(MODULUS)) begin
            rem1 = r_r3 - REM_W'(MODULUS);
        end else begin
            rem1 = r_r3;
        end
        sum     = rem1 + REM_W'(r_c3);
        sum_red = (sum >= REM_W'(MODULUS)) ? sum - REM_W'(MODULUS) : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        r_p1  <= PROD_W'(i_a) * PROD_W'(i_b);
        r_c1  <= i_c;
        r_t1  <= i_tag;
        r_q2  <= recip_prod[RECIP_SHIFT +: QUO_W];
        r_p2  <= r_p1;
        r_c2  <= r_c1;
        r_t2  <= r_t1;
        r_r3  <= diff[REM_W-1:0];
        r_c3  <= r_c2;
        r_t3  <= r_t2;
        r_res <= sum_red[VAL_W-1:0];
        r_t4  <= r_t3;
    end

    assign o_done = r_v4;
    assign o_busy = r_v1 | r_v2 | r_v3 | r_v4;
    assign o_res  = r_res;
    assign o_tag  = r_t4;

endmodule

// ===== rtl/range_mul_add_point_query_mod.sv =====
// A rejected transaction goes straight to its result; a query reads the raw value
// and passes it through the mod-multiply pipe. Updates and loads visit each covered
// block, compose its tags, and sweep a partly covered block element by element.
// One transaction at a time; the element sweep of partial blocks through the raw-value
// memory read port and the mod-multiply pipe dominates the time a transaction takes.
// Reset is synchronous; block tags are restored to (1, 0), raw memory is not cleared.
// ----------------------------------------------------------------------------
// range_mul_add_point_query_mod
// Range multiply, range add, point query and load over residues mod 10007,
// held as blocks of raw values with lazy multiply and add tags per block.
// ----------------------------------------------------------------------------
module range_mul_add_point_query_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rmapq_pkg::POS_W-1:0] i_cfg_data,
    rmapq_in_if.sink                    i_in,
    rmapq_out_if.source                 o_out
);
    import rmapq_pkg::*;
    `include "range_mul_add_point_query_mod_defines.svh"

    // Sequencer states. A range update visits each covered block: the tag
    // stage composes the block tags with the operation, then a block lying
    // wholly in the range keeps the composed tags, while a partly covered
    // block is swept element by element and its tags return to (1, 0).
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_TAGA  = 10'b0000000010,
        S_TAGB  = 10'b0000000100,
        S_TAGW  = 10'b0000001000,
        S_WALK  = 10'b0000010000,
        S_DRAIN = 10'b0000100000,
        S_NEXT  = 10'b0001000000,
        S_QRD   = 10'b0010000000,
        S_QWAIT = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state            r_state, n_state;

    // Raw values live in a synchronous memory; tags in flip-flops so that
    // reset restores them at once.
    t_val              r_mem [MAX_LEN];
    t_val              r_rdata;
    logic              r_rv;
    t_addr             r_raddr;
    t_val              r_mtag [NUM_BLOCKS];
    t_val              r_atag [NUM_BLOCKS];

    logic [POS_W-1:0]  r_len;
    t_op               r_op;
    t_addr             r_lo, r_hi;
    t_val              r_c;
    logic [BLK_W-1:0]  r_blk, r_bhi;
    logic [OFS_W-1:0]  r_idx;
    t_val              r_m2, r_a2;
    logic              r_got_m;
    t_val              r_value;
    logic              r_status;
    logic              r_out_valid;
    t_val              r_out_value;
    logic              r_out_status;

    // Request decode.
    logic              in_acc;
    logic              is_range;
    logic [POS_W-1:0]  n_eff;
    logic [POS_W-1:0]  end_pos;
    logic [POS_W-1:0]  lo_full, hi_full;
    logic              bad;
    t_val              c_red;

    // Datapath.
    t_val              k_mul, k_add, cur_m, cur_a;
    logic              rd_en;
    t_addr             rd_addr;
    logic              in_rng;
    logic              mm_start, mm_done, mm_busy;
    t_val              mm_a, mm_b, mm_c, mm_res;
    t_addr             mm_tag;
    t_addr             mm_tag_o;
    logic              mem_we;
    t_val              mem_wd;
    t_addr             blk_first, blk_last;
    logic              whole;
    logic              out_free;

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign is_range    = (i_in.operation == OP_MUL) || (i_in.operation == OP_ADD);
    assign n_eff       = (r_len > POS_W'(MAX_LEN)) ? POS_W'(MAX_LEN) : r_len;
    assign end_pos     = is_range ? i_in.right : i_in.left;
    assign lo_full     = i_in.left - POS_W'(1);
    assign hi_full     = end_pos - POS_W'(1);
    assign c_red       = (i_in.operand >= VAL_W'(MODULUS)) ?
                         i_in.operand - VAL_W'(MODULUS) : i_in.operand;

    always_comb begin
        if (is_range) begin
            bad = (i_in.left == '0) || (i_in.left > i_in.right) || (i_in.right > n_eff);
        end else begin
            bad = (i_in.left == '0) || (i_in.left > n_eff);
        end
    end

    // The operation as an affine map x -> x * k_mul + k_add.
    assign k_mul  = (r_op == OP_MUL) ? r_c : VAL_W'(1);
    assign k_add  = (r_op == OP_ADD) ? r_c : '0;
    assign cur_m  = r_mtag[r_blk];
    assign cur_a  = r_atag[r_blk];

    assign rd_en   = (r_state == S_QRD) || (r_state == S_WALK);
    assign rd_addr = (r_state == S_QRD) ? r_lo : {r_blk, r_idx};

    // Elements inside the range take the composed tags, the others only
    // have the old tags pushed into them. A query always uses the old tags.
    assign in_rng  = (r_raddr >= r_lo) && (r_raddr <= r_hi) && (r_state != S_QWAIT);

    always_comb begin
        mm_start = 1'b0;
        mm_a     = r_rdata;
        mm_b     = in_rng ? r_m2 : cur_m;
        mm_c     = in_rng ? r_a2 : cur_a;
        mm_tag   = r_raddr;
        case (r_state)
            S_TAGA: begin
                mm_start = 1'b1;
                mm_a     = cur_m;
                mm_b     = k_mul;
                mm_c     = '0;
            end
            S_TAGB: begin
                mm_start = 1'b1;
                mm_a     = cur_a;
                mm_b     = k_mul;
                mm_c     = k_add;
            end
            default: begin
                mm_start = r_rv;
            end
        endcase
    end

    rmapq_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .i_c     (mm_c),
        .i_tag   (mm_tag),
        .o_done  (mm_done),
        .o_busy  (mm_busy),
        .o_res   (mm_res),
        .o_tag   (mm_tag_o)
    );

    // Write-back of the sweep. A load overrides its own position with the
    // new value after the block's tags have been pushed down.
    assign mem_we = mm_done && ((r_state == S_WALK) || (r_state == S_DRAIN));
    assign mem_wd = ((r_op == OP_LOAD) && (mm_tag_o == r_lo)) ? r_c : mm_res;

    assign blk_first = {r_blk, {OFS_W{1'b0}}};
    assign blk_last  = {r_blk, {OFS_W{1'b1}}};
    assign whole     = (r_lo <= blk_first) && (blk_last <= r_hi);
    assign out_free  = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (bad) begin
                        n_state = S_DONE;
                    end else if (i_in.operation == OP_QUERY) begin
                        n_state = S_QRD;
                    end else begin
                        n_state = S_TAGA;
                    end
                end
            end
            S_TAGA:  n_state = S_TAGB;
            S_TAGB:  n_state = S_TAGW;
            S_TAGW: begin
                if (mm_done && r_got_m) begin
                    n_state = whole ? S_NEXT : S_WALK;
                end
            end
            S_WALK: begin
                if (r_idx == {OFS_W{1'b1}}) begin
                    n_state = S_DRAIN;
                end
            end
            // Every write of the block lands before the next block is read.
            S_DRAIN: begin
                if (!r_rv && !mm_busy) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT:  n_state = (r_blk == r_bhi) ? S_DONE : S_TAGA;
            S_QRD:   n_state = S_QWAIT;
            S_QWAIT: begin
                if (mm_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Raw value memory, one read and one write port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mm_tag_o] <= mem_wd;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        r_raddr <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= POS_W'(MAX_LEN);
            r_rv        <= 1'b0;
            r_got_m     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int b = 0; b < NUM_BLOCKS; b++) begin
                r_mtag[b] <= VAL_W'(1);
                r_atag[b] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_rv    <= rd_en;
            if (i_cfg_we) begin
                r_len <= i_cfg_data;
            end
            case (r_state)
                S_TAGW: begin
                    if (mm_done) begin
                        r_got_m <= !r_got_m;
                        if (r_got_m && whole) begin
                            r_mtag[r_blk] <= r_m2;
                            r_atag[r_blk] <= mm_res;
                        end
                    end
                end
                S_DRAIN: begin
                    if (!r_rv && !mm_busy) begin
                        r_mtag[r_blk] <= VAL_W'(1);
                        r_atag[r_blk] <= '0;
                    end
                end
                default: begin
                end
            endcase
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers of the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op     <= i_in.operation;
                r_lo     <= lo_full[ADDR_W-1:0];
                r_hi     <= hi_full[ADDR_W-1:0];
                r_c      <= c_red;
                r_blk    <= lo_full[ADDR_W-1:OFS_W];
                r_bhi    <= hi_full[ADDR_W-1:OFS_W];
                r_value  <= '0;
                r_status <= bad;
            end
            S_TAGW: begin
                r_idx <= '0;
                if (mm_done) begin
                    if (!r_got_m) begin
                        r_m2 <= mm_res;
                    end else begin
                        r_a2 <= mm_res;
                    end
                end
            end
            S_WALK: begin
                r_idx <= r_idx + OFS_W'(1);
            end
            S_NEXT: begin
                if (r_blk != r_bhi) begin
                    r_blk <= r_blk + BLK_W'(1);
                end
            end
            S_QWAIT: begin
                if (mm_done) begin
                    r_value <= mm_res;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_value  <= r_value;
                    r_out_status <= r_status;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.value  = r_out_value;
    assign o_out.status = r_out_status;

    // Memory writes come only from the element sweep.
    `RMAPQ_ASSERT(a_we_in_sweep, i_clk, i_rst_n, mem_we |-> (r_state == S_WALK || r_state == S_DRAIN))
    // The sweep hands over to the next block only once the pipe is empty.
    `RMAPQ_ASSERT(a_drain_empty, i_clk, i_rst_n, (r_state == S_DRAIN && n_state == S_NEXT) |-> (!mm_busy && !r_rv))
    // A new result only ever follows the completion state.
    `RMAPQ_ASSERT(a_result_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_DONE))
    // The arithmetic pipe never finishes work while the block is idle.
    `RMAPQ_ASSERT(a_no_stray_done, i_clk, i_rst_n, mm_done |-> (r_state != S_IDLE && r_state != S_DONE))
    // Reset leaves no result pending.
    `RMAPQ_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !r_out_valid)

endmodule
